// ===== hdl/c2d_pkg.sv =====
// Package for the 9x9 convolution filter: sizes, register indexes, kernel tables.
`default_nettype none
package c2d_pkg;
	localparam int Win = 9;
	localparam int Ctr = 4;
	localparam int NTaps = Win * Win;
	localparam int MaxWidth = 1024;
	localparam int MaxHeight = 4096;
	localparam int FracBits = 12;
	localparam int CoefW = 20;
	localparam int AccW = 36;
	localparam int LsW = 8 * (Win - 1);
	localparam int TwoSigmaSq = 8;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KSEL   = 2'd2
	} reg_idx_t;

	typedef logic signed [CoefW-1:0] coef_t;

	// 1-D Gaussian factors e(d), Q16, d = 0..7
	function automatic logic [16:0] tap_exp(input int d);
		logic [16:0] e;
		int a;
		begin
			a = (d < 0) ? -d : d;
			case (a % 8)
				0: e = 17'd65536;
				1: e = 17'd57835;
				2: e = 17'd39750;
				3: e = 17'd21276;
				4: e = 17'd8869;
				5: e = 17'd2879;
				6: e = 17'd728;
				7: e = 17'd143;
				default: e = 17'd0;
			endcase
			return e;
		end
	endfunction

	// sum of the 1-D factors over the window
	function automatic longint exp_sum();
		longint s;
		begin
			s = 0;
			for (int i = -Ctr; i <= Ctr; i++) s += longint'(tap_exp(i));
			return s;
		end
	endfunction

	// second moment of the 1-D factors over the window
	function automatic longint exp_m2();
		longint m2;
		begin
			m2 = 0;
			for (int i = -Ctr; i <= Ctr; i++)
				m2 += longint'(i * i) * longint'(tap_exp(i));
			return m2;
		end
	endfunction

	// product e(|x|)*e(|y|) for tap k (row-major)
	function automatic longint tap_prod(input int k);
		int x, y;
		begin
			y = k / Win - Ctr;
			x = k % Win - Ctr;
			return longint'(tap_exp(x)) * longint'(tap_exp(y));
		end
	endfunction

	// LoG radial weight 2*sigma^2 - x^2 - y^2 for tap k
	function automatic longint tap_wt(input int k);
		int x, y;
		begin
			y = k / Win - Ctr;
			x = k % Win - Ctr;
			return longint'(TwoSigmaSq) - longint'(x * x + y * y);
		end
	endfunction

	// normalization terms, all fixed at elaboration
	localparam longint ExpSum = exp_sum();
	localparam longint ExpM2 = exp_m2();
	localparam longint GaussDen = ExpSum * ExpSum;
	localparam longint LogDen = ExpSum * (longint'(TwoSigmaSq) * ExpSum - 2 * ExpM2);
	localparam longint LogMag = (LogDen < 0) ? -LogDen : LogDen;
	localparam longint LogDiv = (LogMag == 0) ? 64'sd1 : LogMag;
	localparam longint CoefSat = 64'sd2147483647;
endpackage
`default_nettype wire

// ===== hdl/conv2d_9x9_kernel_filter_unit.sv =====
// Top level of the 9x9 streaming convolution filter (Gaussian or LoG).
`default_nettype none
// Streaming 9x9 convolution on 8-bit raster pixels, one word per clock sustained unless
// input stall is high. Eight previous rows live in one 1024-entry line memory, 64 bits
// wide (one byte per row); each column is read when its word is accepted and rewritten
// from stage 1; a one-entry forward covers a read of the column just written. After its
// input word is accepted, a result passes memory read at acceptance, then window shift,
// tap multiply, two adder-tree stages and clamp into the output register. The line
// memory is cleared after reset by a pass over all 1024 entries, one entry a cycle,
// during which input stall stays high; configuration is accepted throughout.
// Border positions produce no word. Downstream stall freezes the whole pipeline.
module conv2d_9x9_kernel_filter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  pixel_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       pixel_out,
	output logic [11:0]      out_row,
	output logic [9:0]       out_col,
	output logic             frame_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	localparam int W = c2d_pkg::Win;
	localparam int NT = c2d_pkg::NTaps;
	localparam int LsW = c2d_pkg::LsW;
	localparam int PW = 8 + c2d_pkg::CoefW;
	localparam int AW = c2d_pkg::AccW;

	// config registers
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic        ksel_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1024;
			height_q <= 13'd1024;
			ksel_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				c2d_pkg::REG_WIDTH:  width_q <= cfg_data[10:0];
				c2d_pkg::REG_HEIGHT: height_q <= cfg_data;
				c2d_pkg::REG_KSEL:   ksel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [10:0] w_eff;
	logic [12:0] h_eff;
	always_comb begin
		w_eff = (width_q == 11'd0) ? 11'd1 : (width_q > 11'd1024 ? 11'd1024 : width_q);
		h_eff = (height_q == 13'd0) ? 13'd1 : (height_q > 13'd4096 ? 13'd4096 : height_q);
	end

	// fixed kernels, one constant coefficient per tap
	c2d_pkg::coef_t kg [NT];
	c2d_pkg::coef_t kl [NT];
	for (genvar gi = 0; gi < NT; gi++) begin : g_coef
		localparam longint P = c2d_pkg::tap_prod(gi);
		localparam longint Wt = c2d_pkg::tap_wt(gi);
		localparam longint Wm = (Wt < 0) ? -Wt : Wt;
		localparam longint QG =
			((P << c2d_pkg::FracBits) + c2d_pkg::GaussDen / 2) / c2d_pkg::GaussDen;
		localparam longint QR =
			(((Wm * P) << c2d_pkg::FracBits) + c2d_pkg::LogDiv / 2) / c2d_pkg::LogDiv;
		localparam longint QL = (c2d_pkg::LogMag == 0) ? 64'sd0 :
			((QR > c2d_pkg::CoefSat) ? c2d_pkg::CoefSat : QR);
		localparam bit Neg = (Wt < 0) != (c2d_pkg::LogDen < 0);
		assign kg[gi] = c2d_pkg::coef_t'(QG);
		assign kl[gi] = Neg ? c2d_pkg::coef_t'(-QL) : c2d_pkg::coef_t'(QL);
	end

	// clearing pass
	logic [10:0] clr_q;
	logic        clr_busy;
	assign clr_busy = !clr_q[10];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= 11'd0;
		else if (clr_busy) clr_q <= clr_q + 11'd1;
	end

	// pipeline advance: stall freezes everything when output word is held
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = clr_busy || !adv;
	logic acc_in;
	assign acc_in = in_valid && !in_stall;

	// counters
	logic [11:0] row_q;
	logic [9:0]  col_q;
	logic        col_wrap, row_wrap;
	assign col_wrap = ({1'b0, col_q} + 11'd1) >= w_eff;
	assign row_wrap = ({1'b0, row_q} + 13'd1) >= h_eff;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc_in) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	// stage 1: memory read issued; carry pixel and position
	logic [LsW-1:0] mem [c2d_pkg::MaxWidth];
	logic [LsW-1:0] rd_s1;
	logic           v_s1, res_s1, last_s1;
	logic [7:0]     pix_s1;
	logic [9:0]     col_s1;
	logic [11:0]    row_s1;
	logic           fwd_s1;
	logic [LsW-1:0] col_word;
	logic [LsW-1:0] wr_s2;
	logic           v_s2;

	always_ff @(posedge clk) begin
		if (acc_in) rd_s1 <= mem[col_q];
		if (clr_busy) mem[clr_q[9:0]] <= '0;
		else if (v_s1 && adv) mem[col_s1] <= col_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_in;
			// same column written this edge by stage 1 (width 1 case)
			fwd_s1 <= acc_in && v_s1 && (col_s1 == col_q);
		end
	end
	always_ff @(posedge clk) begin
		if (acc_in) begin
			pix_s1 <= pixel_in;
			col_s1 <= col_q;
			row_s1 <= row_q - 12'(c2d_pkg::Ctr);
			res_s1 <= (row_q >= 12'(W - 1)) && (col_q >= 10'(W - 1));
			last_s1 <= row_wrap && col_wrap;
		end
	end

	// column of nine: byte k = row k (oldest at 0); new store shifts rows up
	logic [LsW-1:0] rd_eff;
	logic [LsW-1:0] held_q;
	assign rd_eff = fwd_s1 ? held_q : rd_s1;
	assign col_word = {pix_s1, rd_eff[LsW-1:8]};
	always_ff @(posedge clk) begin
		if (v_s1 && adv) held_q <= col_word;
	end

	// stage 2: window shift
	logic [7:0] win_q [NT];
	logic       last_s2;
	logic [9:0] oc_s2;
	logic [11:0] or_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int i = 0; i < NT; i++) win_q[i] <= 8'd0;
		end else if (adv) begin
			v_s2 <= v_s1 && res_s1;
			if (v_s1) begin
				for (int k = 0; k < W; k++) begin
					for (int m = 0; m < W - 1; m++) win_q[k*W+m] <= win_q[k*W+m+1];
					win_q[k*W+W-1] <= (k == W - 1) ? pix_s1 : rd_eff[k*8 +: 8];
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			last_s2 <= last_s1;
			or_s2 <= row_s1;
			oc_s2 <= col_s1 - 10'(c2d_pkg::Ctr);
			wr_s2 <= col_word;
		end
	end

	// stage 3: products
	logic signed [PW-1:0] prod_s3 [NT];
	logic v_s3, last_s3;
	logic [9:0] oc_s3;
	logic [11:0] or_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NT; i++)
				prod_s3[i] <= PW'($signed({1'b0, win_q[i]})) *
					PW'(ksel_q ? kl[i] : kg[i]);
			last_s3 <= last_s2;
			oc_s3 <= oc_s2;
			or_s3 <= or_s2;
		end
	end

	// stage 4: nine row sums, each a balanced tree
	logic signed [AW-1:0] rsum_d [W];
	always_comb begin
		for (int k = 0; k < W; k++) begin
			rsum_d[k] = ((AW'(prod_s3[k*W]) + AW'(prod_s3[k*W+1]))
				+ (AW'(prod_s3[k*W+2]) + AW'(prod_s3[k*W+3])))
				+ ((AW'(prod_s3[k*W+4]) + AW'(prod_s3[k*W+5]))
				+ (AW'(prod_s3[k*W+6]) + AW'(prod_s3[k*W+7])))
				+ AW'(prod_s3[k*W+8]);
		end
	end

	logic signed [AW-1:0] rsum_s4 [W];
	logic v_s4, last_s4;
	logic [9:0] oc_s4;
	logic [11:0] or_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < W; k++) rsum_s4[k] <= rsum_d[k];
			last_s4 <= last_s3;
			oc_s4 <= oc_s3;
			or_s4 <= or_s3;
		end
	end

	// stage 5: total of the row sums
	logic signed [AW-1:0] acc_d;
	assign acc_d = ((rsum_s4[0] + rsum_s4[1]) + (rsum_s4[2] + rsum_s4[3]))
		+ ((rsum_s4[4] + rsum_s4[5]) + (rsum_s4[6] + rsum_s4[7])) + rsum_s4[8];

	logic signed [AW-1:0] acc_s5;
	logic v_s5, last_s5;
	logic [9:0] oc_s5;
	logic [11:0] or_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5 <= acc_d;
			last_s5 <= last_s4;
			oc_s5 <= oc_s4;
			or_s5 <= or_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	// output register: truncate and clamp
	logic [AW-1:0] sh;
	assign sh = AW'(acc_s5 >>> c2d_pkg::FracBits);
	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc_s5 <= 0) pixel_out <= 8'd0;
			else if (sh > AW'(255)) pixel_out <= 8'd255;
			else pixel_out <= sh[7:0];
			out_row <= or_s5;
			out_col <= oc_s5;
			frame_last <= last_s5;
		end
	end

`ifndef SYNTHESIS
	a_no_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall) else $error("input taken during clear");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pixel_out)))
		else $error("result lost under stall");
	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv) |=> v_s3) else $error("pipeline dropped word");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv && !clr_busy) |=> (wr_s2 == $past(col_word)))
		else $error("line write mismatch");
`endif
endmodule
`default_nettype wire

// ===== bench/conv2d_9x9_kernel_filter_unit_tb.sv =====
// Self-checking bench for the 9x9 Gaussian / LoG streaming convolution filter.
`default_nettype none
module conv2d_9x9_kernel_filter_unit_tb;

	typedef struct packed {
		logic [7:0]  pix;
		logic [11:0] row;
		logic [9:0]  col;
		logic        last;
	} filt_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  pixel_out;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        frame_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	// predictor copy of the block
	logic [7:0]  line_mem [0:7][0:1023];
	logic [7:0]  win_q [0:8][0:8];
	logic [11:0] row_q;
	logic [9:0]  col_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic        ksel_q;
	longint      gauss_k [0:80];
	longint      log_k [0:80];

	filt_word_t  expected_words[$];
	int          err_count = 0;
	bit          no_idle = 1'b0;
	int          stall_left = 0;

	always #4 clk = ~clk;

	conv2d_9x9_kernel_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
		.out_row(out_row), .out_col(out_col), .frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Q16 samples of exp(-d*d/8), index wraps at 8
	function automatic longint gexp(input int d);
		longint tbl [0:7];
		tbl = '{65536, 57835, 39750, 21276, 8869, 2879, 728, 143};
		return tbl[(d < 0 ? -d : d) % 8];
	endfunction

	// fixed-point Gaussian and LoG coefficients, 12 fractional bits
	task automatic build_coefs();
		longint s, m2, den_g, den_l, mag, p, w, wm, q;
		s = 0;
		m2 = 0;
		for (int i = -4; i <= 4; i++) begin
			s += gexp(i);
			m2 += longint'(i * i) * gexp(i);
		end
		den_g = s * s;
		den_l = s * (8 * s - 2 * m2);
		mag = den_l < 0 ? -den_l : den_l;
		for (int y = -4; y <= 4; y++) begin
			for (int x = -4; x <= 4; x++) begin
				p = gexp(x) * gexp(y);
				gauss_k[(y + 4) * 9 + x + 4] = ((p << 12) + den_g / 2) / den_g;
				w = 8 - longint'(x * x + y * y);
				wm = w < 0 ? -w : w;
				if (mag == 0) begin
					q = 0;
				end else begin
					q = ((wm * p << 12) + mag / 2) / mag;
					if (q > 64'sd2147483647) q = 64'sd2147483647;
				end
				log_k[(y + 4) * 9 + x + 4] = ((w < 0) != (den_l < 0)) ? -q : q;
			end
		end
	endtask

	// advance the filter model by one pixel; queue the word it yields, if any
	task automatic filter_pixel(input logic [7:0] pix);
		logic [7:0] column [0:8];
		int w, h, r, c;
		longint acc;
		filt_word_t fw;
		w = width_q == 0 ? 1 : (width_q > 1024 ? 1024 : int'(width_q));
		h = height_q == 0 ? 1 : (height_q > 4096 ? 4096 : int'(height_q));
		r = row_q;
		c = col_q;
		for (int k = 0; k < 8; k++) column[k] = line_mem[k][c];
		column[8] = pix;
		for (int k = 0; k < 8; k++) line_mem[k][c] = column[k + 1];
		for (int k = 0; k < 9; k++) begin
			for (int m = 0; m < 8; m++) win_q[k][m] = win_q[k][m + 1];
			win_q[k][8] = column[k];
		end
		if (r >= 8 && c >= 8) begin
			acc = 0;
			for (int k = 0; k < 81; k++)
				acc += longint'(win_q[k / 9][k % 9]) * (ksel_q ? log_k[k] : gauss_k[k]);
			fw.pix = acc <= 0 ? 8'd0 : ((acc >>> 12) > 255 ? 8'd255 : 8'(acc >>> 12));
			fw.row = 12'(r - 4);
			fw.col = 10'(c - 4);
			fw.last = (r + 1 >= h) && (c + 1 >= w);
			expected_words.push_back(fw);
		end
		if (c + 1 >= w) begin
			col_q = '0;
			row_q = (r + 1 >= h) ? 12'd0 : 12'(r + 1);
		end else begin
			col_q = 10'(c + 1);
		end
	endtask

	// send one pixel word after a random gap; predict at acceptance
	task automatic send_pixel(input logic [7:0] pix);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (in_stall);
		filter_pixel(pix);
	endtask

	// all words out, then room for a border word still in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input c2d_pkg::reg_idx_t idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			c2d_pkg::REG_WIDTH:  width_q = val[10:0];
			c2d_pkg::REG_HEIGHT: height_q = val;
			c2d_pkg::REG_KSEL:   ksel_q = val[0];
			default: ;
		endcase
	endtask

	task automatic set_shape(input logic [12:0] w, input logic [12:0] h, input logic ks);
		write_reg(c2d_pkg::REG_WIDTH, w);
		write_reg(c2d_pkg::REG_HEIGHT, h);
		write_reg(c2d_pkg::REG_KSEL, {12'd0, ks});
	endtask

	// random image content: smooth ramps, flat patches, edges and noise
	function automatic logic [7:0] scene_pixel(input int mode, input int n);
		case (mode)
			0: return 8'($urandom);
			1: return 8'(n * 3);
			2: return ((n / 5) % 2) ? 8'hFF : 8'h00;
			default: return 8'(128 + $urandom_range(0, 16) - 8);
		endcase
	endfunction

	// output side: stall for a random count after each accepted word
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			stall_left = no_idle ? 0 : $urandom_range(0, 4);
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end
		out_stall <= stall_left > 0;
	end

	// compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		filt_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word pix=%0d row=%0d col=%0d last=%0b",
					$time, pixel_out, out_row, out_col, frame_last);
				err_count++;
			end else begin
				want = expected_words.pop_front();
				if (want != {pixel_out, out_row, out_col, frame_last}) begin
					$display("%0t: mismatch exp pix=%0d row=%0d col=%0d last=%0b", $time,
						want.pix, want.row, want.col, want.last);
					$display("%0t:          got pix=%0d row=%0d col=%0d last=%0b", $time,
						pixel_out, out_row, out_col, frame_last);
					err_count++;
				end
			end
		end
	end

	// smallest frame, flat black, flat white and a checker, both kernels
	task automatic test_small_frames();
		for (int ks = 0; ks < 2; ks++) begin
			set_shape(13'd9, 13'd9, ks[0]);
			for (int n = 0; n < 81; n++) send_pixel(8'hFF);
			for (int n = 0; n < 81; n++) send_pixel(8'h00);
			for (int n = 0; n < 81; n++) send_pixel(((n + n / 9) % 2) ? 8'hFF : 8'h00);
			drain();
		end
	endtask

	// zero and oversize registers, sizes under the kernel, full line width
	task automatic test_register_limits();
		set_shape(13'd0, 13'd0, 1'b0);
		for (int n = 0; n < 20; n++) send_pixel(8'($urandom));
		drain();
		set_shape(13'd5, 13'd30, 1'b1);
		for (int n = 0; n < 60; n++) send_pixel(8'($urandom));
		drain();
		set_shape(13'd2047, 13'd8191, 1'b1);
		for (int n = 0; n < 40; n++) send_pixel(8'($urandom));
		drain();
		set_shape(13'd1024, 13'd9, 1'b0);
		no_idle = 1'b1;
		for (int n = 0; n < 150; n++) send_pixel(scene_pixel(n % 4, n));
		no_idle = 1'b0;
		drain();
		set_shape(13'd12, 13'd4096, 1'b1);
		for (int n = 0; n < 100; n++) send_pixel(scene_pixel(0, n));
		drain();
	endtask

	// random shapes, kernels and content, changes land mid-frame
	task automatic test_random_frames();
		int mode, len;
		for (int blk = 0; blk < 10; blk++) begin
			set_shape(13'($urandom_range(9, 16)), 13'($urandom_range(9, 14)),
				1'($urandom));
			no_idle = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 3);
			len = $urandom_range(40, 80);
			for (int n = 0; n < len; n++)
				send_pixel($urandom_range(0, 9) == 0 ? 8'($urandom) : scene_pixel(mode, n));
			no_idle = 1'b0;
			drain();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		for (int k = 0; k < 8; k++)
			for (int c = 0; c < 1024; c++) line_mem[k][c] = '0;
		for (int k = 0; k < 9; k++)
			for (int m = 0; m < 9; m++) win_q[k][m] = '0;
		row_q = '0;
		col_q = '0;
		width_q = 11'd1024;
		height_q = 13'd1024;
		ksel_q = 1'b0;
		build_coefs();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_small_frames();
		test_register_limits();
		test_random_frames();
		drain();
		if (err_count == 0 && expected_words.size() == 0) begin
			$display("conv2d_9x9_kernel_filter_unit_tb: clean");
		end else begin
			$display("conv2d_9x9_kernel_filter_unit_tb: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(8 * 2000000);
		$display("conv2d_9x9_kernel_filter_unit_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/c2d_pkg.sv
hdl/conv2d_9x9_kernel_filter_unit.sv
bench/conv2d_9x9_kernel_filter_unit_tb.sv
